FILE: rtl/sti_pkg.sv
`timescale 1ns / 1ps

package sti_pkg;

    localparam int TABLE_DEPTH_DEFAULT = 64;

    localparam int KEY_W  = 16;
    localparam int VAL_W  = 32;
    localparam int ST_W   = 3;
    localparam int DEN_W  = 16;
    localparam int PROD_W = 49;
    localparam int MAG_W  = 33;

    localparam logic [ST_W-1:0] ST_STORED = 3'd0;
    localparam logic [ST_W-1:0] ST_FULL   = 3'd1;
    localparam logic [ST_W-1:0] ST_EXACT  = 3'd2;
    localparam logic [ST_W-1:0] ST_INTERP = 3'd3;
    localparam logic [ST_W-1:0] ST_RANGE  = 3'd4;

    localparam logic KIND_STORE = 1'b0;
    localparam logic KIND_QUERY = 1'b1;

    typedef struct packed {
        logic busy;
        logic done;
    } sti_div_stat_t;

endpackage

FILE: rtl/sti_mem.sv
`timescale 1ns / 1ps

module sti_mem #(
    parameter int DEPTH = sti_pkg::TABLE_DEPTH_DEFAULT,
    parameter int AW    = $clog2(DEPTH),
    parameter int DW    = sti_pkg::KEY_W + sti_pkg::VAL_W
) (
    input  logic          aclk,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  logic [DW-1:0] wr_data,
    input  logic [AW-1:0] rd_addr,
    output logic [DW-1:0] rd_data
);

    logic [DW-1:0] mem [DEPTH];
    logic [DW-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: rtl/sti_div.sv
`timescale 1ns / 1ps

module sti_div (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             start,
    input  logic [sti_pkg::PROD_W-1:0]       dividend,
    input  logic [sti_pkg::DEN_W-1:0]        divisor,
    output logic [sti_pkg::PROD_W-1:0]       quotient,
    output sti_pkg::sti_div_stat_t           stat
);

    localparam int CNT_W = $clog2(sti_pkg::PROD_W + 1);

    logic [sti_pkg::PROD_W-1:0] dvd_reg, dvd_next;
    logic [sti_pkg::DEN_W-1:0]  rem_reg, rem_next;
    logic [sti_pkg::DEN_W-1:0]  den_reg, den_next;
    logic [CNT_W-1:0]           cnt_reg, cnt_next;
    logic                       busy_reg, busy_next;
    logic                       done_reg, done_next;
    logic [sti_pkg::DEN_W:0]    rem_sh;
    logic                       ge;

    // One restoring step per cycle, most significant dividend bit first.
    always_comb begin
        rem_sh    = {rem_reg, dvd_reg[sti_pkg::PROD_W-1]};
        ge        = rem_sh >= {1'b0, den_reg};
        dvd_next  = dvd_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start && !busy_reg) begin
            dvd_next  = dividend;
            rem_next  = '0;
            den_next  = divisor;
            cnt_next  = CNT_W'(sti_pkg::PROD_W);
            busy_next = 1'b1;
        end else if (busy_reg) begin
            rem_next = ge ? sti_pkg::DEN_W'(rem_sh - {1'b0, den_reg})
                          : rem_sh[sti_pkg::DEN_W-1:0];
            dvd_next = {dvd_reg[sti_pkg::PROD_W-2:0], ge};
            cnt_next = cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        dvd_reg <= dvd_next;
        rem_reg <= rem_next;
        den_reg <= den_next;
    end

    assign quotient  = dvd_reg;
    assign stat.busy = busy_reg;
    assign stat.done = done_reg;

endmodule

FILE: rtl/spectrum_table_interpolator.sv
`timescale 1ns / 1ps
// One request at a time; the input is not ready until its result is in the output register.
// Every request first runs a binary search over N stored points.
// An insert then moves each entry above the new point with a read and a write; an overwrite writes in place.
// An interpolated query adds a multiply and a serial divide.
// Synchronous active-low reset empties the table and clears the state machine and the output valid.
module spectrum_table_interpolator #(
    parameter int TABLE_DEPTH = sti_pkg::TABLE_DEPTH_DEFAULT
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,   // wavelength [15:0], sample_value [47:16]
    input  logic        s_tuser,   // kind
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // result_value [31:0]
    output logic [2:0]  m_tuser    // status [2:0]
);

    localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CW = $clog2(TABLE_DEPTH + 1);
    localparam int KW = sti_pkg::KEY_W;
    localparam int VW = sti_pkg::VAL_W;

    typedef enum logic [12:0] {
        S_IDLE      = 13'b0000000000001,
        S_SRCH      = 13'b0000000000010,
        S_SRCH_CMP  = 13'b0000000000100,
        S_PROBE     = 13'b0000000001000,
        S_PROBE_CMP = 13'b0000000010000,
        S_NEIGH     = 13'b0000000100000,
        S_MUL       = 13'b0000001000000,
        S_DIV_GO    = 13'b0000010000000,
        S_DIV_WAIT  = 13'b0000100000000,
        S_SHIFT_RD  = 13'b0001000000000,
        S_SHIFT_WR  = 13'b0010000000000,
        S_INS_WR    = 13'b0100000000000,
        S_FINISH    = 13'b1000000000000
    } state_t;

    state_t state_reg, state_next;

    logic [CW-1:0] count_reg, count_next;
    logic [CW-1:0] lo_reg, lo_next;
    logic [CW-1:0] hi_reg, hi_next;
    logic [CW-1:0] mid_reg, mid_next;
    logic [CW-1:0] j_reg, j_next;
    logic          kind_reg, kind_next;
    logic [KW-1:0] w_reg, w_next;
    logic [VW-1:0] v_reg, v_next;
    logic          hit_reg, hit_next;
    logic [KW-1:0] kb_reg, kb_next;
    logic [VW-1:0] fb_reg, fb_next;
    logic [VW-1:0] fa_reg, fa_next;
    logic          neg_reg, neg_next;
    logic [sti_pkg::MAG_W-1:0]  mag_reg, mag_next;
    logic [KW-1:0] num_reg, num_next;
    logic [sti_pkg::DEN_W-1:0]  den_reg, den_next;
    logic [sti_pkg::PROD_W-1:0] prod_reg, prod_next;
    logic [VW-1:0] res_val_reg, res_val_next;
    logic [sti_pkg::ST_W-1:0]   res_st_reg, res_st_next;
    logic          m_tvalid_reg, m_tvalid_next;
    logic [VW-1:0] m_tdata_reg, m_tdata_next;
    logic [sti_pkg::ST_W-1:0]   m_tuser_reg, m_tuser_next;

    logic          wr_en;
    logic [AW-1:0] wr_addr;
    logic [KW+VW-1:0] wr_data;
    logic [AW-1:0] rd_addr;
    logic [KW+VW-1:0] rd_data;
    logic [KW-1:0] rd_key;
    logic [VW-1:0] rd_val;

    logic [CW:0]   mid_sum;
    logic [VW:0]   diff;
    logic          div_start;
    logic [sti_pkg::PROD_W-1:0] quotient;
    sti_pkg::sti_div_stat_t     div_stat;
    logic [VW+1:0] sq;
    logic [VW+1:0] sum;

    assign rd_key  = rd_data[KW+VW-1:VW];
    assign rd_val  = rd_data[VW-1:0];
    assign mid_sum = {1'b0, lo_reg} + {1'b0, hi_reg};
    assign diff    = {fb_reg[VW-1], fb_reg} - {rd_val[VW-1], rd_val};
    assign sq      = neg_reg ? (VW+2)'(-{1'b0, quotient[VW:0]})
                             : (VW+2)'({1'b0, quotient[VW:0]});
    assign sum     = {{2{fa_reg[VW-1]}}, fa_reg} + sq;

    sti_mem #(
        .DEPTH (TABLE_DEPTH),
        .AW    (AW),
        .DW    (KW + VW)
    ) u_mem (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    sti_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (prod_reg),
        .divisor  (den_reg),
        .quotient (quotient),
        .stat     (div_stat)
    );

    always_comb begin
        state_next    = state_reg;
        count_next    = count_reg;
        lo_next       = lo_reg;
        hi_next       = hi_reg;
        mid_next      = mid_reg;
        j_next        = j_reg;
        kind_next     = kind_reg;
        w_next        = w_reg;
        v_next        = v_reg;
        hit_next      = hit_reg;
        kb_next       = kb_reg;
        fb_next       = fb_reg;
        fa_next       = fa_reg;
        neg_next      = neg_reg;
        mag_next      = mag_reg;
        num_next      = num_reg;
        den_next      = den_reg;
        prod_next     = prod_reg;
        res_val_next  = res_val_reg;
        res_st_next   = res_st_reg;
        m_tvalid_next = m_tvalid_reg;
        m_tdata_next  = m_tdata_reg;
        m_tuser_next  = m_tuser_reg;
        wr_en         = 1'b0;
        wr_addr       = lo_reg[AW-1:0];
        wr_data       = {w_reg, v_reg};
        rd_addr       = lo_reg[AW-1:0];
        div_start     = 1'b0;

        if (m_tvalid_reg && m_tready) begin
            m_tvalid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    kind_next  = s_tuser;
                    w_next     = s_tdata[15:0];
                    v_next     = s_tdata[47:16];
                    lo_next    = '0;
                    hi_next    = count_reg;
                    hit_next   = 1'b0;
                    state_next = S_SRCH;
                end
            end
            S_SRCH: begin
                mid_next = mid_sum[CW:1];
                rd_addr  = mid_sum[AW:1];
                if (lo_reg == hi_reg) begin
                    state_next = S_PROBE;
                end else begin
                    state_next = S_SRCH_CMP;
                end
            end
            S_SRCH_CMP: begin
                if (rd_key < w_reg) begin
                    lo_next = mid_reg + CW'(1);
                end else begin
                    hi_next = mid_reg;
                end
                state_next = S_SRCH;
            end
            S_PROBE: begin
                rd_addr = lo_reg[AW-1:0];
                if (lo_reg < count_reg) begin
                    state_next = S_PROBE_CMP;
                end else if (kind_reg == sti_pkg::KIND_QUERY) begin
                    res_val_next = '0;
                    res_st_next  = sti_pkg::ST_RANGE;
                    state_next   = S_FINISH;
                end else if (count_reg >= CW'(TABLE_DEPTH)) begin
                    res_val_next = '0;
                    res_st_next  = sti_pkg::ST_FULL;
                    state_next   = S_FINISH;
                end else begin
                    state_next = S_INS_WR;
                end
            end
            S_PROBE_CMP: begin
                rd_addr  = AW'(lo_reg - CW'(1));
                kb_next  = rd_key;
                fb_next  = rd_val;
                hit_next = (rd_key == w_reg);
                j_next   = count_reg;
                if (kind_reg == sti_pkg::KIND_STORE) begin
                    if (rd_key == w_reg) begin
                        state_next = S_INS_WR;
                    end else if (count_reg >= CW'(TABLE_DEPTH)) begin
                        res_val_next = '0;
                        res_st_next  = sti_pkg::ST_FULL;
                        state_next   = S_FINISH;
                    end else begin
                        state_next = S_SHIFT_RD;
                    end
                end else if (rd_key == w_reg) begin
                    res_val_next = rd_val;
                    res_st_next  = sti_pkg::ST_EXACT;
                    state_next   = S_FINISH;
                end else if (lo_reg == '0) begin
                    res_val_next = '0;
                    res_st_next  = sti_pkg::ST_RANGE;
                    state_next   = S_FINISH;
                end else begin
                    state_next = S_NEIGH;
                end
            end
            S_NEIGH: begin
                fa_next    = rd_val;
                neg_next   = diff[VW];
                mag_next   = diff[VW] ? sti_pkg::MAG_W'(-diff) : sti_pkg::MAG_W'(diff);
                num_next   = w_reg - rd_key;
                den_next   = kb_reg - rd_key;
                state_next = S_MUL;
            end
            S_MUL: begin
                prod_next  = sti_pkg::PROD_W'(mag_reg) * sti_pkg::PROD_W'(num_reg);
                state_next = S_DIV_GO;
            end
            S_DIV_GO: begin
                div_start  = 1'b1;
                state_next = S_DIV_WAIT;
            end
            S_DIV_WAIT: begin
                if (div_stat.done) begin
                    res_val_next = sum[VW-1:0];
                    res_st_next  = sti_pkg::ST_INTERP;
                    state_next   = S_FINISH;
                end
            end
            S_SHIFT_RD: begin
                rd_addr = AW'(j_reg - CW'(1));
                if (j_reg == lo_reg) begin
                    state_next = S_INS_WR;
                end else begin
                    state_next = S_SHIFT_WR;
                end
            end
            S_SHIFT_WR: begin
                wr_en      = 1'b1;
                wr_addr    = j_reg[AW-1:0];
                wr_data    = rd_data;
                j_next     = j_reg - CW'(1);
                state_next = S_SHIFT_RD;
            end
            S_INS_WR: begin
                wr_en = 1'b1;
                if (!hit_reg) begin
                    count_next = count_reg + CW'(1);
                end
                res_val_next = '0;
                res_st_next  = sti_pkg::ST_STORED;
                state_next   = S_FINISH;
            end
            S_FINISH: begin
                if (!m_tvalid_reg || m_tready) begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = res_val_reg;
                    m_tuser_next  = res_st_reg;
                    state_next    = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            count_reg    <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            count_reg    <= count_next;
            m_tvalid_reg <= m_tvalid_next;
        end
        lo_reg      <= lo_next;
        hi_reg      <= hi_next;
        mid_reg     <= mid_next;
        j_reg       <= j_next;
        kind_reg    <= kind_next;
        w_reg       <= w_next;
        v_reg       <= v_next;
        hit_reg     <= hit_next;
        kb_reg      <= kb_next;
        fb_reg      <= fb_next;
        fa_reg      <= fa_next;
        neg_reg     <= neg_next;
        mag_reg     <= mag_next;
        num_reg     <= num_next;
        den_reg     <= den_next;
        prod_reg    <= prod_next;
        res_val_reg <= res_val_next;
        res_st_reg  <= res_st_next;
        m_tdata_reg <= m_tdata_next;
        m_tuser_reg <= m_tuser_next;
    end

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    // The point count never grows past the table depth.
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CW'(TABLE_DEPTH))
        else $error("point count exceeds table depth");

    // A new request is not taken in the cycle after one was accepted.
    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("request accepted while busy");

    // The divider is only started when it is idle.
    a_div_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        div_start |-> !div_stat.busy)
        else $error("divider restarted while busy");

    // Store and out-of-range results carry a zero value.
    a_zero_value: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && (m_tuser == sti_pkg::ST_STORED || m_tuser == sti_pkg::ST_FULL
                      || m_tuser == sti_pkg::ST_RANGE)) |-> (m_tdata == '0))
        else $error("nonzero value on a store or out-of-range result");

endmodule

FILE: verif/sti_table_monitor.sv
`timescale 1ns / 1ps

module sti_table_monitor #(
    parameter int TABLE_DEPTH = sti_pkg::TABLE_DEPTH_DEFAULT
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [47:0] s_tdata,
    input  logic        s_tuser,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [31:0] m_tdata,
    input  logic [2:0]  m_tuser,
    output int          mismatch_count,
    output int          answers_owed
);

    typedef struct packed {
        logic [sti_pkg::VAL_W-1:0] value;
        logic [sti_pkg::ST_W-1:0]  status;
    } answer_t;

    logic [sti_pkg::KEY_W-1:0] point_wl [TABLE_DEPTH];
    logic [sti_pkg::VAL_W-1:0] point_val [TABLE_DEPTH];
    int               points_held;
    answer_t          expected_answers [$];

    task automatic report_mismatch(input string what, input logic [31:0] want,
                                   input logic [31:0] got);
        $display("MISMATCH %s: expected %h, got %h at %0t", what, want, got, $time);
        mismatch_count++;
    endtask

    function automatic answer_t apply_table_request(input logic kind,
                                                    input logic [sti_pkg::KEY_W-1:0] w,
                                                    input logic [sti_pkg::VAL_W-1:0] v);
        answer_t          ans;
        int               slot;
        longint           lo_val;
        longint           hi_val;
        longint           delta;
        longint           step;
        logic [63:0]      magnitude;
        logic [63:0]      quotient;
        logic [sti_pkg::KEY_W-1:0] offset;
        logic [sti_pkg::KEY_W-1:0] span;
        ans.value  = '0;
        ans.status = sti_pkg::ST_STORED;
        slot = 0;
        while (slot < points_held && point_wl[slot] < w) slot++;
        if (kind == sti_pkg::KIND_STORE) begin
            if (slot < points_held && point_wl[slot] == w) begin
                point_val[slot] = v;
            end else if (points_held >= TABLE_DEPTH) begin
                ans.status = sti_pkg::ST_FULL;
            end else begin
                for (int j = points_held; j > slot; j--) begin
                    point_wl[j]  = point_wl[j-1];
                    point_val[j] = point_val[j-1];
                end
                point_wl[slot]  = w;
                point_val[slot] = v;
                points_held++;
            end
        end else if (slot >= points_held || (slot == 0 && point_wl[0] != w)) begin
            ans.status = sti_pkg::ST_RANGE;
        end else if (point_wl[slot] == w) begin
            ans.value  = point_val[slot];
            ans.status = sti_pkg::ST_EXACT;
        end else begin
            lo_val    = $signed(point_val[slot-1]);
            hi_val    = $signed(point_val[slot]);
            delta     = hi_val - lo_val;
            magnitude = (delta < 0) ? -delta : delta;
            offset    = w - point_wl[slot-1];
            span      = point_wl[slot] - point_wl[slot-1];
            quotient  = (magnitude * offset) / span;
            step      = (delta < 0) ? -longint'(quotient) : longint'(quotient);
            ans.value  = sti_pkg::VAL_W'(lo_val + step);
            ans.status = sti_pkg::ST_INTERP;
        end
        return ans;
    endfunction

    always @(posedge aclk) begin
        answer_t oldest;
        if (!aresetn) begin
            points_held = 0;
            expected_answers.delete();
            mismatch_count = 0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (expected_answers.size() == 0) begin
                    report_mismatch("result with no request pending", '0, m_tdata);
                end else begin
                    oldest = expected_answers.pop_front();
                    if (m_tdata !== oldest.value)
                        report_mismatch("result_value", oldest.value, m_tdata);
                    if (m_tuser !== oldest.status)
                        report_mismatch("status", 32'(oldest.status), 32'(m_tuser));
                end
            end
            if (s_tvalid && s_tready)
                expected_answers.push_back(apply_table_request(s_tuser, s_tdata[15:0],
                                                               s_tdata[47:16]));
        end
        answers_owed = expected_answers.size();
    end

endmodule

FILE: verif/tb.sv
`timescale 1ns / 1ps

module tb;

    localparam int STALL_LIMIT     = 3000;
    localparam int LONG_HOLD       = 400;
    localparam int RANDOM_REQUESTS = 900;
    localparam int CALM_FROM       = 800;
    localparam logic [31:0] VAL_MIN = 32'h8000_0000;
    localparam logic [31:0] VAL_MAX = 32'h7FFF_FFFF;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [47:0] s_tdata  = '0;
    logic        s_tuser  = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;
    logic [2:0]  m_tuser;
    int          mismatch_count;
    int          answers_owed;

    bit          calm = 1'b0;
    bit          hold_request = 1'b0;
    int          hold_left = 0;
    int          idle_cycles = 0;
    logic [15:0] sent_keys [$];

    spectrum_table_interpolator u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    sti_table_monitor u_monitor (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_tvalid       (s_tvalid),
        .s_tready       (s_tready),
        .s_tdata        (s_tdata),
        .s_tuser        (s_tuser),
        .m_tvalid       (m_tvalid),
        .m_tready       (m_tready),
        .m_tdata        (m_tdata),
        .m_tuser        (m_tuser),
        .mismatch_count (mismatch_count),
        .answers_owed   (answers_owed)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    task automatic send_request(input logic kind, input logic [15:0] w,
                                input logic [31:0] v);
        if (!calm && $urandom_range(0, 7) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= {v, w};
        if (kind == sti_pkg::KIND_STORE) sent_keys.push_back(w);
        do @(posedge aclk); while (!s_tready);
        @(negedge aclk);
    endtask

    task automatic drain_results();
        s_tvalid <= 1'b0;
        do @(negedge aclk); while (answers_owed != 0);
    endtask

    always begin
        @(negedge aclk);
        if (hold_request) begin
            hold_left = LONG_HOLD;
            hold_request = 1'b0;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_tready <= 1'b0;
        end else if (!calm && $urandom_range(0, 9) == 0) begin
            hold_left = $urandom_range(0, 14);
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles == STALL_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        logic        kind;
        logic [15:0] w;
        logic [15:0] ka;
        logic [16:0] mid;
        logic [31:0] v;
        int          sel;
        repeat (7) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Queries on the empty table, then edges around one and two points, an overwrite and more points.
        send_request(sti_pkg::KIND_QUERY, 16'd1000, $urandom());
        send_request(sti_pkg::KIND_QUERY, 16'h0000, $urandom());
        send_request(sti_pkg::KIND_QUERY, 16'hFFFF, $urandom());
        send_request(sti_pkg::KIND_STORE, 16'd1, VAL_MIN);
        send_request(sti_pkg::KIND_QUERY, 16'd1, $urandom());
        send_request(sti_pkg::KIND_QUERY, 16'h0000, $urandom());
        send_request(sti_pkg::KIND_QUERY, 16'd2, $urandom());
        send_request(sti_pkg::KIND_STORE, 16'hFFFE, VAL_MAX);
        send_request(sti_pkg::KIND_QUERY, 16'd2, $urandom());
        send_request(sti_pkg::KIND_QUERY, 16'hFFFD, $urandom());
        send_request(sti_pkg::KIND_QUERY, 16'h8000, $urandom());
        send_request(sti_pkg::KIND_STORE, 16'd1000, 32'h0000_0000);
        send_request(sti_pkg::KIND_QUERY, 16'd500, $urandom());
        send_request(sti_pkg::KIND_STORE, 16'd1000, 32'hFFFF_FFFF);
        send_request(sti_pkg::KIND_QUERY, 16'd1000, $urandom());
        send_request(sti_pkg::KIND_QUERY, 16'hFFFF, $urandom());
        send_request(sti_pkg::KIND_STORE, 16'd3000, 32'h1234_5678);
        send_request(sti_pkg::KIND_STORE, 16'd20000, 32'hC000_0000);
        send_request(sti_pkg::KIND_QUERY, 16'd10000, $urandom());
        send_request(sti_pkg::KIND_QUERY, 16'd1001, $urandom());
        send_request(sti_pkg::KIND_QUERY, 16'hFFFE, $urandom());
        drain_results();

        for (int n = 0; n < RANDOM_REQUESTS; n++) begin
            calm = (n >= CALM_FROM);
            if (n == 120) hold_request = 1'b1;
            if (n == 300) drain_results();
            kind = ($urandom_range(0, 99) < (n < 400 ? 45 : 30)) ? sti_pkg::KIND_STORE
                                                                 : sti_pkg::KIND_QUERY;
            sel  = $urandom_range(0, 9);
            ka   = sent_keys[$urandom_range(0, sent_keys.size() - 1)];
            case ($urandom_range(0, 9))
                0:       v = VAL_MIN;
                1:       v = VAL_MAX;
                2:       v = 32'h0000_0000;
                3:       v = 32'hFFFF_FFFF;
                default: v = $urandom();
            endcase
            if (kind == sti_pkg::KIND_STORE) begin
                case (sel)
                    0, 1, 2, 3, 4: w = 16'($urandom_range(0, 65535));
                    5, 6, 7:       w = ka;
                    default:       w = ka + 16'($urandom_range(1, 3));
                endcase
            end else begin
                case (sel)
                    0, 1, 2: w = ka;
                    3, 4, 5: w = 16'($urandom_range(0, 65535));
                    6, 7: begin
                        mid = {1'b0, ka} + {1'b0, sent_keys[$urandom_range(0,
                                                               sent_keys.size() - 1)]};
                        w = mid[16:1];
                    end
                    8:       w = ka + ($urandom_range(0, 1) ? 16'h0001 : 16'hFFFF);
                    default: w = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
                endcase
            end
            if (n == 40 || n == 41) begin
                kind = sti_pkg::KIND_STORE;
                w    = (n == 40) ? 16'h0000 : 16'hFFFF;
            end
            send_request(kind, w, v);
        end
        drain_results();
        repeat (200) @(negedge aclk);
        if (mismatch_count == 0 && answers_owed == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

FILE: sim.f
rtl/sti_pkg.sv
rtl/sti_mem.sv
rtl/sti_div.sv
rtl/spectrum_table_interpolator.sv
verif/sti_table_monitor.sv
verif/tb.sv
